// ===== sv/facam_pkg.sv =====
// ============================================================================
// facam_pkg: shared types and constants for the freed address log
// Opcodes, result codes, controller states, the stored entry layout and the
// command word sent from the controller to the row of log cells.
// ============================================================================
`default_nettype none

package facam_pkg;

    localparam int ADDR_W            = 64;
    localparam int SITE_W            = 16;
    localparam int LINE_W            = 20;
    localparam int PREV_W            = SITE_W + LINE_W;
    localparam int OP_W              = 2;
    localparam int STATUS_W          = 3;
    localparam int S_DATA_W          = 176;
    localparam int DEFAULT_LOG_DEPTH = 64;

    // Bit positions of the request fields in s_tdata
    localparam int ADDR_LSB      = 0;
    localparam int FREE_SITE_LSB = 132;
    localparam int FREE_LINE_LSB = 148;

    typedef enum logic [OP_W-1:0] {
        OP_CHECKED_FREE = 2'd0,
        OP_RECORD_FREE  = 2'd1,
        OP_ALLOC        = 2'd2,
        OP_CLEAR        = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_RECORDED      = 3'd0,
        STS_EVICTED       = 3'd1,
        STS_DOUBLE_FREE   = 3'd2,
        STS_STALE_DROPPED = 3'd3,
        STS_NO_RECORD     = 3'd4,
        STS_CLEARED       = 3'd5,
        STS_IGNORED       = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_LOOK   = 2'd1,
        ST_UPDATE = 2'd2
    } state_t;

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] addr;
        logic [SITE_W-1:0] site;
        logic [LINE_W-1:0] line;
    } entry_t;

    typedef struct packed {
        logic clear;          // drop every entry
        logic capture;        // compare key and latch the hit flag
        logic push_all;       // shift the whole row toward the old end
        logic push_to_hit;    // shift only the cells up to the hit cell
        logic pull_from_hit;  // close the gap left by the hit cell
    } cell_cmd_t;

endpackage

`default_nettype wire

// ===== sv/facam_cell.sv =====
// ============================================================================
// facam_cell: one position of the freed address log
// Holds one entry, compares it against the lookup key, and takes its
// neighbor's entry when the row shifts in either direction.
// ============================================================================
`default_nettype none

module facam_cell
    import facam_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cell_cmd_t         cmd,
    input  wire logic [ADDR_W-1:0] key,
    input  wire entry_t            prev_entry,   // newer neighbor
    input  wire entry_t            next_entry,   // older neighbor
    input  wire logic              after_in,     // hit in an older cell
    input  wire logic              before_in,    // hit in a newer cell
    output entry_t                 entry,
    output logic                   hit,
    output logic                   after_out,
    output logic                   before_out
);

    logic              valid_reg, valid_next;
    logic              hit_reg, hit_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [SITE_W-1:0] site_reg, site_next;
    logic [LINE_W-1:0] line_reg, line_next;
    logic              push, pull;

    assign after_out  = hit_reg | after_in;
    assign before_out = hit_reg | before_in;
    assign push       = cmd.push_all | (cmd.push_to_hit & after_out);
    assign pull       = cmd.pull_from_hit & before_out;

    assign hit   = hit_reg;
    assign entry = '{valid: valid_reg, addr: addr_reg, site: site_reg, line: line_reg};

    always_comb
    begin
        valid_next = valid_reg;
        addr_next  = addr_reg;
        site_next  = site_reg;
        line_next  = line_reg;
        hit_next   = hit_reg;
        if (cmd.capture)
        begin
            hit_next = valid_reg && (addr_reg == key);
        end
        if (cmd.clear)
        begin
            valid_next = 1'b0;
        end
        else if (push)
        begin
            valid_next = prev_entry.valid;
            addr_next  = prev_entry.addr;
            site_next  = prev_entry.site;
            line_next  = prev_entry.line;
        end
        else if (pull)
        begin
            valid_next = next_entry.valid;
            addr_next  = next_entry.addr;
            site_next  = next_entry.site;
            line_next  = next_entry.line;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            hit_reg   <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        site_reg <= site_next;
        line_reg <= line_next;
    end

endmodule

`default_nettype wire

// ===== sv/freed_address_log_cam_core.sv =====
// ============================================================================
// freed_address_log_cam_core: double free detector over a log of freed blocks
// Row of LOG_DEPTH cells ordered by age, newest in cell 0, with a controller.
// ============================================================================
// Usage:
//   s_* carries one request per accepted beat: opcode in s_tuser, address and
//   free details in s_tdata. m_* returns exactly one result per request:
//   status in m_tuser, earlier free site/line and record count in m_tdata.
//   cfg_* writes tracking_enable; cfg_ready is always high. Enabling from the
//   disabled state empties the log.
//   Each request goes through accept, parallel key compare in every cell,
//   then one shift of the cell row. The compare and the row shift share the
//   cells, so a new request is taken only once the previous one has shifted
//   the row; the result enters the output register with that shift.
//   When m_tready is low the finished result is held in the output register
//   and the next request is still accepted; its update waits until the
//   output register frees.
//   Reset empties the log, disables tracking and drops any pending result.
// ============================================================================
`default_nettype none

module freed_address_log_cam_core
    import facam_pkg::*;
#(
    parameter  int LOG_DEPTH = DEFAULT_LOG_DEPTH,
    localparam int CNT_W     = $clog2(LOG_DEPTH + 1),
    localparam int M_DATA_W  = ((PREV_W + CNT_W + 7) / 8) * 8
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // address, block_size, alloc_site, alloc_line_no, free_site, free_line_no,
    // trace_level
    input  wire logic [S_DATA_W-1:0] s_tdata,
    // opcode
    input  wire logic [OP_W-1:0]     s_tuser,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // prev_free_site, prev_free_line, record_count
    output logic [M_DATA_W-1:0]      m_tdata,
    // status
    output logic [STATUS_W-1:0]      m_tuser,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic                cfg_data
);

    state_t            state_reg, state_next;
    logic              en_reg, en_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    op_t               op_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [SITE_W-1:0] site_reg;
    logic [LINE_W-1:0] line_reg;

    logic              m_tvalid_reg, m_tvalid_next;
    status_t           out_status_reg, status_next;
    logic [SITE_W-1:0] out_site_reg;
    logic [LINE_W-1:0] out_line_reg;
    logic [CNT_W-1:0]  out_count_reg;

    cell_cmd_t         cmd;
    logic              accept, fire, full, hit_any, take_prev;
    entry_t            new_entry;
    entry_t            ent [LOG_DEPTH];
    logic [LOG_DEPTH-1:0] hit;
    logic [LOG_DEPTH:0]   after_c;
    logic [LOG_DEPTH:0]   before_c;
    logic [SITE_W-1:0] hit_site;
    logic [LINE_W-1:0] hit_line;

    assign accept    = s_tvalid && s_tready;
    assign fire      = (state_reg == ST_UPDATE) && (!m_tvalid_reg || m_tready);
    assign full      = (count_reg == CNT_W'(LOG_DEPTH));
    assign cfg_ready = 1'b1;
    assign new_entry = '{valid: 1'b1, addr: addr_reg, site: site_reg, line: line_reg};

    // ---------------- cell row ----------------
    assign after_c[LOG_DEPTH] = 1'b0;
    assign before_c[0]        = 1'b0;
    assign hit_any            = after_c[0];

    for (genvar i = 0; i < LOG_DEPTH; i++)
    begin : g_cell
        entry_t prev_e, next_e;
        if (i == 0)
        begin : g_head
            assign prev_e = new_entry;
        end
        else
        begin : g_mid
            assign prev_e = ent[i-1];
        end
        if (i == LOG_DEPTH - 1)
        begin : g_tail
            assign next_e = '0;
        end
        else
        begin : g_inner
            assign next_e = ent[i+1];
        end

        facam_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .key        (addr_reg),
            .prev_entry (prev_e),
            .next_entry (next_e),
            .after_in   (after_c[i+1]),
            .before_in  (before_c[i]),
            .entry      (ent[i]),
            .hit        (hit[i]),
            .after_out  (after_c[i]),
            .before_out (before_c[i+1])
        );
    end

    // At most one cell hits, so an OR of the gated fields selects it
    always_comb
    begin
        hit_site = '0;
        hit_line = '0;
        for (int i = 0; i < LOG_DEPTH; i++)
        begin
            hit_site = hit_site | (ent[i].site & {SITE_W{hit[i]}});
            hit_line = hit_line | (ent[i].line & {LINE_W{hit[i]}});
        end
    end

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------- outputs and commands ----------------
    always_comb
    begin
        s_tready    = 1'b0;
        cmd         = '0;
        status_next = STS_IGNORED;
        count_next  = count_reg;
        take_prev   = 1'b0;
        en_next     = en_reg;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            ST_LOOK:
            begin
                cmd.capture = 1'b1;
            end
            ST_UPDATE:
            begin
                if (fire && en_reg &&
                    !(op_reg == OP_CHECKED_FREE && addr_reg == '0))
                begin
                    case (op_reg)
                        OP_CHECKED_FREE:
                        begin
                            if (hit_any)
                            begin
                                status_next = STS_DOUBLE_FREE;
                                take_prev   = 1'b1;
                            end
                            else
                            begin
                                cmd.push_all = 1'b1;
                                status_next  = full ? STS_EVICTED : STS_RECORDED;
                                if (!full)
                                begin
                                    count_next = count_reg + CNT_W'(1);
                                end
                            end
                        end
                        OP_RECORD_FREE:
                        begin
                            if (hit_any)
                            begin
                                // move to front: cell 0 takes it, cells up to the hit shift, older ones hold
                                cmd.push_to_hit = 1'b1;
                                status_next     = STS_RECORDED;
                            end
                            else
                            begin
                                cmd.push_all = 1'b1;
                                status_next  = full ? STS_EVICTED : STS_RECORDED;
                                if (!full)
                                begin
                                    count_next = count_reg + CNT_W'(1);
                                end
                            end
                        end
                        OP_ALLOC:
                        begin
                            if (hit_any)
                            begin
                                cmd.pull_from_hit = 1'b1;
                                status_next       = STS_STALE_DROPPED;
                                count_next        = count_reg - CNT_W'(1);
                            end
                            else
                            begin
                                status_next = STS_NO_RECORD;
                            end
                        end
                        OP_CLEAR:
                        begin
                            cmd.clear   = 1'b1;
                            status_next = STS_CLEARED;
                            count_next  = '0;
                        end
                        default:
                        begin
                            status_next = STS_IGNORED;
                        end
                    endcase
                end
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
        if (cfg_valid)
        begin
            en_next = cfg_data;
            // turning tracking on starts from an empty log
            if (cfg_data && !en_reg)
            begin
                cmd.clear  = 1'b1;
                count_next = '0;
            end
        end
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (fire)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            en_reg       <= 1'b0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            en_reg       <= en_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= op_t'(s_tuser);
            addr_reg <= s_tdata[ADDR_LSB +: ADDR_W];
            site_reg <= s_tdata[FREE_SITE_LSB +: SITE_W];
            line_reg <= s_tdata[FREE_LINE_LSB +: LINE_W];
        end
        if (fire)
        begin
            out_status_reg <= status_next;
            out_site_reg   <= take_prev ? hit_site : '0;
            out_line_reg   <= take_prev ? hit_line : '0;
            out_count_reg  <= count_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = M_DATA_W'({out_count_reg, out_line_reg, out_site_reg});

endmodule

`default_nettype wire

// ===== sv/facam_checker.sv =====
// ============================================================================
// facam_checker: port-level checks for the freed address log
// Watches the request and result channels of the top level over time.
// ============================================================================
`default_nettype none

module facam_checker
    import facam_pkg::*;
#(
    parameter  int LOG_DEPTH = DEFAULT_LOG_DEPTH,
    parameter  int M_DATA_W  = 48,
    localparam int CNT_W     = $clog2(LOG_DEPTH + 1)
)
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                s_tvalid,
    input wire logic                s_tready,
    input wire logic                m_tvalid,
    input wire logic                m_tready,
    input wire logic [M_DATA_W-1:0] m_tdata,
    input wire logic [STATUS_W-1:0] m_tuser
);

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // one request in flight: no accept right after an accept
    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while previous one still in work");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser <= STS_IGNORED)
        else $error("undefined status code");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[PREV_W +: CNT_W] <= CNT_W'(LOG_DEPTH))
        else $error("record count beyond log depth");

    // earlier free site and line only accompany a double free
    a_prev_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != STS_DOUBLE_FREE) |-> m_tdata[PREV_W-1:0] == '0)
        else $error("earlier free details on a result that is no double free");

endmodule

bind freed_address_log_cam_core facam_checker #(
    .LOG_DEPTH (LOG_DEPTH),
    .M_DATA_W  (M_DATA_W)
) u_facam_checker (.*);

`default_nettype wire
